// ----- rtl/stbs_pkg.sv -----
package stbs_pkg;

  localparam int COUNT_W = 21;

  typedef enum logic [1:0] {
    RK_PROBE     = 2'd0,
    RK_FOUND     = 2'd1,
    RK_NOT_FOUND = 2'd2,
    RK_IDLE_ERR  = 2'd3
  } result_kind_t;

  typedef enum logic [1:0] {
    FK_FIRST  = 2'd0,
    FK_ANY    = 2'd1,
    FK_LAST   = 2'd2,
    FK_UNUSED = 2'd3
  } find_kind_t;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_RESP  = 1'b1
  } mode_t;

  // Search phase: main binary search, then refinement toward first or last equal.
  typedef enum logic [2:0] {
    PH_MAIN  = 3'b001,
    PH_FIRST = 3'b010,
    PH_LAST  = 3'b100
  } phase_t;

  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;

endpackage

// ----- rtl/stbs_in_if.sv -----
interface stbs_in_if;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [1:0]        find_kind;
  logic signed [1:0] cmp_sign;

  modport source (output valid, output mode, output find_kind, output cmp_sign, input ready);
  modport sink   (input valid, input mode, input find_kind, input cmp_sign, output ready);
endinterface

// ----- rtl/stbs_out_if.sv -----
interface stbs_out_if #(
  parameter int INDEX_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            result_kind;
  logic [INDEX_BITS-1:0] entry_index;

  modport source (output valid, output result_kind, output entry_index, input ready);
  modport sink   (input valid, input result_kind, input entry_index, output ready);
endinterface

// ----- rtl/sorted_table_bound_search.sv -----
// Each result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle; the interval update and the next probe
// index are computed in one pass from the search registers into the result register.
// The input is taken whenever the result register is empty or being emptied.
// Synchronous active-low reset: idle, empty interval, entry_count 0, no result pending.
module sorted_table_bound_search #(
  parameter int INDEX_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [stbs_pkg::COUNT_W-1:0]  cfg_wdata,
  stbs_in_if.sink                       in_ch,
  stbs_out_if.source                    out_ch
);
  import stbs_pkg::*;

  localparam int CW    = INDEX_BITS + 1;
  localparam int CMP_W = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [CMP_W-1:0] MAX_SPAN_EXT = CMP_W'(1) << INDEX_BITS;
  localparam logic [CW-1:0]    MAX_SPAN     = CW'(MAX_SPAN_EXT);

  logic [COUNT_W-1:0]    entry_count_r;
  logic                  busy_r, busy_nxt;
  phase_t                phase_r, phase_nxt;
  find_kind_t            kind_r, kind_nxt;
  logic [CW-1:0]         low_r, low_nxt;
  logic [CW-1:0]         span_r, span_nxt;
  logic [INDEX_BITS-1:0] probe_r, probe_nxt;

  logic                  out_valid_r;
  result_kind_t          rk_r, rk_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;

  logic                  in_acc;
  logic [CW-1:0]         probe_ext;
  logic [CW-1:0]         span_start;
  logic                  sgn_zero, sgn_pos;
  logic                  do_main, do_refine;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = rk_r;
  assign out_ch.entry_index = idx_r;

  assign probe_ext  = CW'(probe_r);
  assign span_start = (CMP_W'(entry_count_r) > MAX_SPAN_EXT) ? MAX_SPAN
                                                              : CW'(CMP_W'(entry_count_r));
  assign sgn_zero   = (in_ch.cmp_sign == SIGN_ZERO);
  assign sgn_pos    = (in_ch.cmp_sign == SIGN_POS);

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    low_nxt   = low_r;
    span_nxt  = span_r;
    probe_nxt = probe_r;
    rk_nxt    = RK_IDLE_ERR;
    idx_nxt   = '0;
    do_main   = 1'b0;
    do_refine = 1'b0;

    if (in_ch.mode == MODE_START) begin
      kind_nxt  = (find_kind_t'(in_ch.find_kind) == FK_UNUSED) ? FK_ANY
                                                                : find_kind_t'(in_ch.find_kind);
      phase_nxt = PH_MAIN;
      low_nxt   = '0;
      span_nxt  = span_start;
      busy_nxt  = 1'b1;
      do_main   = 1'b1;
    end else if (busy_r) begin
      unique case (phase_r)
        PH_MAIN: begin
          if (sgn_pos) begin
            span_nxt = probe_ext - low_r;
            do_main  = 1'b1;
          end else if (!sgn_zero) begin
            span_nxt = low_r + span_r - (probe_ext + CW'(1));
            low_nxt  = probe_ext + CW'(1);
            do_main  = 1'b1;
          end else if (kind_r == FK_FIRST) begin
            span_nxt  = probe_ext + CW'(1) - low_r;
            phase_nxt = PH_FIRST;
            do_refine = 1'b1;
          end else if (kind_r == FK_LAST) begin
            span_nxt  = low_r + span_r - probe_ext;
            low_nxt   = probe_ext;
            phase_nxt = PH_LAST;
            do_refine = 1'b1;
          end else begin
            busy_nxt = 1'b0;
            rk_nxt   = RK_FOUND;
            idx_nxt  = probe_r;
          end
        end
        PH_FIRST: begin
          // Any nonzero sign moves the interval past the probe.
          if (sgn_zero) begin
            span_nxt = probe_ext + CW'(1) - low_r;
          end else begin
            span_nxt = low_r + span_r - (probe_ext + CW'(1));
            low_nxt  = probe_ext + CW'(1);
          end
          do_refine = 1'b1;
        end
        PH_LAST: begin
          if (sgn_zero) begin
            span_nxt = low_r + span_r - probe_ext;
            low_nxt  = probe_ext;
          end else begin
            span_nxt = probe_ext - low_r;
          end
          do_refine = 1'b1;
        end
        default: begin
          do_refine = 1'b1;
        end
      endcase
    end

    if (do_main) begin
      if (span_nxt == '0) begin
        busy_nxt = 1'b0;
        rk_nxt   = RK_NOT_FOUND;
      end else begin
        probe_nxt = INDEX_BITS'(low_nxt + (span_nxt >> 1));
        rk_nxt    = RK_PROBE;
        idx_nxt   = probe_nxt;
      end
    end else if (do_refine) begin
      if (span_nxt <= CW'(1)) begin
        busy_nxt = 1'b0;
        rk_nxt   = RK_FOUND;
        idx_nxt  = INDEX_BITS'(low_nxt);
      end else begin
        probe_nxt = INDEX_BITS'(low_nxt + (span_nxt >> 1));
        rk_nxt    = RK_PROBE;
        idx_nxt   = probe_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      busy_r        <= 1'b0;
      phase_r       <= PH_MAIN;
      kind_r        <= FK_FIRST;
      low_r         <= '0;
      span_r        <= '0;
      probe_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        entry_count_r <= cfg_wdata;
      end
      if (in_acc) begin
        busy_r  <= busy_nxt;
        phase_r <= phase_nxt;
        kind_r  <= kind_nxt;
        low_r   <= low_nxt;
        span_r  <= span_nxt;
        probe_r <= probe_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload carries no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rk_r  <= rk_nxt;
      idx_r <= idx_nxt;
    end
  end

  a_span_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (CW+1)'(low_r) + (CW+1)'(span_r) <= (CW+1)'(MAX_SPAN))
    else $error("search interval exceeds table");

  a_probe_in_interval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rk_r == RK_PROBE |->
      busy_r && probe_ext >= low_r && (CW+1)'(probe_ext) < (CW+1)'(low_r) + (CW+1)'(span_r))
    else $error("pending probe outside search interval");

  a_done_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (rk_r == RK_FOUND || rk_r == RK_NOT_FOUND) |-> !busy_r)
    else $error("search still busy after final result");

  a_start_answers: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.mode == MODE_START |=> phase_r == PH_MAIN && (busy_r || rk_r == RK_NOT_FOUND))
    else $error("start did not open a main search");

  a_idle_err_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.mode == MODE_RESP && busy_r |=> rk_r != RK_IDLE_ERR)
    else $error("protocol error reported during search");

endmodule

// ----- bench/tb_sorted_table_bound_search.sv -----
module tb_sorted_table_bound_search;
  timeunit 1ns;
  timeprecision 1ps;

  import stbs_pkg::*;

  localparam int IDX_W = 20;
  localparam int ITEMS = 550;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_RESP = 2 * IDX_W + 8;
  localparam logic [COUNT_W-1:0] MAX_SPAN = COUNT_W'(1) << IDX_W;
  localparam logic [COUNT_W-1:0] COUNT_ALL_ONES = '1;
  localparam logic [1:0] SIGN_NEG = 2'b11;
  localparam logic [1:0] SIGN_NEG_ALT = 2'b10;

  class search_scoreboard;
    typedef struct packed {
      result_kind_t          kind;
      logic [IDX_W-1:0]      index;
    } result_t;

    result_t             expected_q[$];
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  low_bound;
    logic [COUNT_W-1:0]  span;
    logic [COUNT_W-1:0]  probe_idx;
    logic                busy;
    phase_t              phase;
    find_kind_t          kind_held;
    result_kind_t        last_kind;
    logic [IDX_W-1:0]    last_index;
    int                  errors;

    function new();
      count_reg  = '0;
      low_bound  = '0;
      span       = '0;
      probe_idx  = '0;
      busy       = 1'b0;
      phase      = PH_MAIN;
      kind_held  = FK_FIRST;
      last_kind  = RK_IDLE_ERR;
      last_index = '0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push(result_kind_t kind, logic [COUNT_W-1:0] idx);
      result_t r;
      r.kind  = kind;
      r.index = idx[IDX_W-1:0];
      expected_q.push_back(r);
      last_kind  = kind;
      last_index = r.index;
    endfunction

    // Probe the midpoint, or close the search once the interval is empty or refined to one entry.
    function void next_probe(bit refine);
      if (!refine && span == 0) begin
        busy = 1'b0;
        push(RK_NOT_FOUND, '0);
      end else if (refine && span <= 1) begin
        busy = 1'b0;
        push(RK_FOUND, low_bound);
      end else begin
        probe_idx = low_bound + span / 2;
        push(RK_PROBE, probe_idx);
      end
    endfunction

    function void note_input(mode_t mode, find_kind_t fk, logic [1:0] sc);
      bit is_zero;
      bit is_pos;
      is_zero = (sc == SIGN_ZERO);
      is_pos  = (sc == SIGN_POS);
      if (mode == MODE_START) begin
        kind_held = (fk == FK_UNUSED) ? FK_ANY : fk;
        phase     = PH_MAIN;
        low_bound = '0;
        span      = (count_reg > MAX_SPAN) ? MAX_SPAN : count_reg;
        busy      = 1'b1;
        next_probe(1'b0);
      end else if (!busy) begin
        push(RK_IDLE_ERR, '0);
      end else if (phase == PH_MAIN) begin
        if (is_pos) begin
          span = probe_idx - low_bound;
          next_probe(1'b0);
        end else if (!is_zero) begin
          span      = low_bound + span - (probe_idx + 1);
          low_bound = probe_idx + 1;
          next_probe(1'b0);
        end else if (kind_held == FK_FIRST) begin
          span  = probe_idx + 1 - low_bound;
          phase = PH_FIRST;
          next_probe(1'b1);
        end else if (kind_held == FK_LAST) begin
          span      = low_bound + span - probe_idx;
          low_bound = probe_idx;
          phase     = PH_LAST;
          next_probe(1'b1);
        end else begin
          busy = 1'b0;
          push(RK_FOUND, probe_idx);
        end
      end else begin
        // In refinement any nonzero sign moves the interval off the probe, toward the equal run.
        if (phase == PH_FIRST) begin
          if (is_zero) begin
            span = probe_idx + 1 - low_bound;
          end else begin
            span      = low_bound + span - (probe_idx + 1);
            low_bound = probe_idx + 1;
          end
        end else begin
          if (is_zero) begin
            span      = low_bound + span - probe_idx;
            low_bound = probe_idx;
          end else begin
            span = probe_idx - low_bound;
          end
        end
        next_probe(1'b1);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [IDX_W-1:0] idx);
      result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind %0d index %0d", $time, kind, idx);
        return;
      end
      exp = expected_q.pop_front();
      if (kind !== exp.kind) begin
        errors++;
        $display("%0t: result_kind expected %0d (%s) actual %0d",
                 $time, exp.kind, exp.kind.name(), kind);
      end
      if (idx !== exp.index) begin
        errors++;
        $display("%0t: entry_index expected %0d actual %0d", $time, exp.index, idx);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  stbs_in_if in_ch ();
  stbs_out_if #(.INDEX_BITS(IDX_W)) out_ch ();

  search_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_sent = 0;
  int stall_cycles = 0;

  sorted_table_bound_search #(
    .INDEX_BITS(IDX_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.result_kind, out_ch.entry_index);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_item(mode_t mode, find_kind_t fk, logic [1:0] sc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.find_kind <= fk;
    in_ch.cmp_sign  <= sc;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_input(mode, fk, sc);
    n_sent++;
  endtask

  // Drain all results, let the block settle, then load a new entry count.
  task automatic write_count(logic [COUNT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.count_reg = value;
  endtask

  // Sign of a table entry against a target whose equal run is [eq_lo, eq_hi).
  function automatic logic [1:0] table_sign(int unsigned idx, int unsigned eq_lo,
                                            int unsigned eq_hi);
    if (idx < eq_lo) begin
      return $urandom_range(1) ? SIGN_NEG : SIGN_NEG_ALT;
    end else if (idx >= eq_hi) begin
      return SIGN_POS;
    end
    return SIGN_ZERO;
  endfunction

  // Cap the responses: a find-first refinement can keep probing the same equal entry.
  task automatic finish_search(int unsigned eq_lo, int unsigned eq_hi, bit noisy);
    logic [1:0] sc;
    int n_resp;
    n_resp = 0;
    while (sb.last_kind == RK_PROBE && n_resp < MAX_RESP) begin
      // Abandon now and then; the next start takes over the running search.
      if (noisy && $urandom_range(99) < 3) return;
      if (noisy && $urandom_range(99) < 4) begin
        sc = 2'($urandom_range(3));
      end else begin
        sc = table_sign(sb.last_index, eq_lo, eq_hi);
      end
      send_item(MODE_RESP, find_kind_t'($urandom_range(3)), sc);
      n_resp++;
    end
  endtask

  task automatic run_search(find_kind_t fk, int unsigned eq_lo, int unsigned eq_hi,
                            bit noisy);
    send_item(MODE_START, fk, 2'($urandom_range(3)));
    finish_search(eq_lo, eq_hi, noisy);
  endtask

  task automatic random_search();
    int unsigned n;
    int unsigned lo;
    int unsigned w;
    int unsigned hi;
    n  = (sb.count_reg > MAX_SPAN) ? MAX_SPAN : sb.count_reg;
    lo = $urandom_range(n, 0);
    w  = n - lo;
    if ($urandom_range(3) == 0) begin
      hi = lo + $urandom_range(w, 0);
    end else begin
      hi = lo + $urandom_range((w < 3) ? w : 3, 0);
    end
    run_search(find_kind_t'($urandom_range(3)), lo, hi, 1'b1);
  endtask

  initial begin
    int idle_plan[3][2];
    int seg;
    int target;
    logic [COUNT_W-1:0] count_val;
    idle_plan = '{'{9, 81}, '{81, 9}, '{0, 0}};
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_START;
    in_ch.find_kind <= FK_FIRST;
    in_ch.cmp_sign  <= SIGN_ZERO;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, then a response with no search running.
    write_count('0);
    send_item(MODE_START, FK_FIRST, SIGN_NEG);
    send_item(MODE_RESP, FK_ANY, SIGN_ZERO);
    write_count(COUNT_W'(1));
    run_search(FK_ANY, 0, 1, 1'b0);
    write_count(COUNT_W'(7));
    run_search(FK_FIRST, 2, 5, 1'b0);
    run_search(FK_LAST, 2, 5, 1'b0);
    run_search(FK_UNUSED, 4, 4, 1'b0);
    // Oversized count saturates; a second start drops the running search.
    write_count(COUNT_ALL_ONES);
    send_item(MODE_START, FK_LAST, SIGN_POS);
    run_search(FK_UNUSED, 1 << 19, (1 << 19) + 1, 1'b0);
    // Count rewritten mid-search only affects the next start.
    write_count(COUNT_W'(9));
    send_item(MODE_START, FK_LAST, SIGN_ZERO);
    write_count(COUNT_W'(2));
    finish_search(4, 9, 1'b0);
    run_search(FK_FIRST, 0, 2, 1'b0);

    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: count_val = COUNT_W'($urandom_range(40, 1));
        1: count_val = COUNT_ALL_ONES;
        2: count_val = COUNT_W'($urandom_range(300, 2));
        3: count_val = MAX_SPAN;
        4: count_val = COUNT_W'($urandom_range(16, 1));
        default: count_val = COUNT_W'($urandom_range(MAX_SPAN, 1));
      endcase
      write_count(count_val);
      send_idle_pct = idle_plan[seg / 2][0];
      recv_idle_pct = idle_plan[seg / 2][1];
      target = n_sent + ITEMS / 6;
      while (n_sent < target) begin
        if ($urandom_range(99) < 75) begin
          random_search();
        end else begin
          send_item(mode_t'($urandom_range(1)), find_kind_t'($urandom_range(3)),
                    2'($urandom_range(3)));
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/stbs_pkg.sv
rtl/stbs_in_if.sv
rtl/stbs_out_if.sv
rtl/sorted_table_bound_search.sv
bench/tb_sorted_table_bound_search.sv
